FILE: rtl/double_ended_priority_queue_defines.svh
// Assertion macros for the double-ended priority queue.
// They expect clk and arst_n in the scope of use.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define DEPQ_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DEPQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DEPQ_ASSERT_IMPL(name, ante, cons, msg)
`define DEPQ_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

FILE: rtl/depq_pkg.sv
`timescale 1ns / 1ps

package depq_pkg;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_MAX    = 2'd1,
		FUNC_MIN    = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_EXTRACTED = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_SHIFT  = 2'd2,
		CMD_TRIM   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] v;
	} chain_ctrl_t;

endpackage

FILE: rtl/double_ended_priority_queue.sv
`timescale 1ns / 1ps
// Double-ended priority queue over signed 32-bit values.
// Input channel: in_valid/in_ready with func (0 insert, 1 extract max,
// 2 extract min; 3 acts as extract min) and value.
// Output channel: out_valid/out_ready with result_value and status
// (0 inserted, 1 extracted, 2 empty, 3 full). Each item gives one result.
// Two chains of CAPACITY cells hold the multiset sorted: one ascending,
// one holding inverted values so its head is the inverted maximum. Every cell
// compares locally against the broadcast value, so the whole chain updates at once.
// An item is held in the input register and its result in the output register.
// Throughput: one item per cycle while out_ready stays high; a full
// input register and output register give two items of buffering.
// When the receiver stalls, the held result stays on the port and one more
// item is taken into the input register, then in_ready drops.
// Reset clears all cell valid bits (empty store) and both stage valid bits;
// no clearing pass is needed and an item is taken the cycle after reset.
module double_ended_priority_queue import depq_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]         status
);

`include "double_ended_priority_queue_defines.svh"

	logic               s1_valid_q;
	func_t              s1_func_q;
	logic signed [31:0] s1_value_q;

	logic               out_valid_q;
	logic signed [31:0] out_result_q;
	status_t            out_status_q;

	logic               exec;
	chain_ctrl_t        a_ctrl;
	chain_ctrl_t        b_ctrl;
	logic signed [31:0] a_head;
	logic signed [31:0] b_head;
	logic               a_nonempty;
	logic               b_nonempty;
	logic               a_full;
	logic               b_full;
	logic signed [31:0] res_d;
	status_t            st_d;

	assign exec     = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (exec) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s1_func_q  <= func_t'(func);
			s1_value_q <= value;
		end
	end

	always_comb begin
		a_ctrl.cmd = CMD_HOLD;
		a_ctrl.v   = s1_value_q;
		b_ctrl.cmd = CMD_HOLD;
		b_ctrl.v   = ~s1_value_q;
		res_d      = '0;
		st_d       = ST_INSERTED;
		unique case (s1_func_q)
			FUNC_INSERT: begin
				if (a_full) begin
					st_d = ST_FULL;
				end else begin
					a_ctrl.cmd = exec ? CMD_INSERT : CMD_HOLD;
					b_ctrl.cmd = exec ? CMD_INSERT : CMD_HOLD;
				end
			end
			FUNC_MAX: begin
				if (!a_nonempty) begin
					st_d = ST_EMPTY;
				end else begin
					res_d      = ~b_head;
					st_d       = ST_EXTRACTED;
					a_ctrl.cmd = exec ? CMD_TRIM : CMD_HOLD;
					b_ctrl.cmd = exec ? CMD_SHIFT : CMD_HOLD;
				end
			end
			default: begin
				if (!a_nonempty) begin
					st_d = ST_EMPTY;
				end else begin
					res_d      = a_head;
					st_d       = ST_EXTRACTED;
					a_ctrl.cmd = exec ? CMD_SHIFT : CMD_HOLD;
					b_ctrl.cmd = exec ? CMD_TRIM : CMD_HOLD;
				end
			end
		endcase
	end

	depq_chain #(
		.CAPACITY (CAPACITY)
	) u_chain_min (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (a_ctrl),
		.head_data (a_head),
		.nonempty  (a_nonempty),
		.full      (a_full)
	);

	// stores inverted values, so the head is the inverted maximum
	depq_chain #(
		.CAPACITY (CAPACITY)
	) u_chain_max (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (b_ctrl),
		.head_data (b_head),
		.nonempty  (b_nonempty),
		.full      (b_full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_result_q <= res_d;
			out_status_q <= st_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_result_q;
	assign status       = out_status_q;

	`DEPQ_ASSERT_IMPL(chk_empty_agree, 1'b1, a_nonempty == b_nonempty, "chains disagree on empty")
	`DEPQ_ASSERT_IMPL(chk_full_agree, 1'b1, a_full == b_full, "chains disagree on full")
	`DEPQ_ASSERT_IMPL(chk_min_le_max, a_nonempty, a_head <= $signed(~b_head), "min above max")
	`DEPQ_ASSERT_NEXT(chk_exec_out, exec, out_valid_q, "executed item gave no result")

endmodule

FILE: rtl/depq_cell.sv
`timescale 1ns / 1ps

module depq_cell import depq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  chain_ctrl_t        ctrl,
	input  logic signed [31:0] left_data,
	input  logic               left_valid,
	input  logic               left_gt,
	input  logic signed [31:0] right_data,
	input  logic               right_valid,
	output logic signed [31:0] data_q,
	output logic               valid_q,
	output logic               gt
);

	logic signed [31:0] data_d;
	logic               valid_d;

	// entry sorts after the broadcast value
	assign gt = valid_q && (data_q > ctrl.v);

	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		unique case (ctrl.cmd)
			CMD_HOLD: begin
			end
			CMD_INSERT: begin
				valid_d = valid_q | left_valid;
				if (left_gt) begin
					data_d = left_data;
				end else if (gt || !valid_q) begin
					data_d = ctrl.v;
				end
			end
			CMD_SHIFT: begin
				data_d  = right_data;
				valid_d = right_valid;
			end
			CMD_TRIM: begin
				valid_d = right_valid;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

endmodule

FILE: rtl/depq_chain.sv
`timescale 1ns / 1ps

module depq_chain import depq_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  chain_ctrl_t        ctrl,
	output logic signed [31:0] head_data,
	output logic               nonempty,
	output logic               full
);

	logic signed [31:0] data  [CAPACITY];
	logic               valid [CAPACITY];
	logic               gt    [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] ld;
		logic signed [31:0] rd;
		logic               lv;
		logic               lg;
		logic               rv;

		if (i == 0) begin : g_first
			assign ld = '0;
			assign lv = 1'b1;
			assign lg = 1'b0;
		end else begin : g_left
			assign ld = data[i-1];
			assign lv = valid[i-1];
			assign lg = gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rd = '0;
			assign rv = 1'b0;
		end else begin : g_right
			assign rd = data[i+1];
			assign rv = valid[i+1];
		end

		depq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_data   (ld),
			.left_valid  (lv),
			.left_gt     (lg),
			.right_data  (rd),
			.right_valid (rv),
			.data_q      (data[i]),
			.valid_q     (valid[i]),
			.gt          (gt[i])
		);
	end

	assign head_data = data[0];
	assign nonempty  = valid[0];
	assign full      = valid[CAPACITY-1];

endmodule

FILE: verif/tb_double_ended_priority_queue.sv
`timescale 1ns / 1ps

module tb_double_ended_priority_queue;
	import depq_pkg::*;

	localparam int CAPACITY = 1024;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic signed [31:0] value;
		status_t            st;
	} depq_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         func = FUNC_INSERT;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0]         status;

	logic signed [31:0] store_model[$];
	depq_result_t       pending_results[$];
	int                 errors = 0;
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;

	double_ended_priority_queue #(.CAPACITY(CAPACITY)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sorted multiset model, ascending signed order
	function automatic depq_result_t predict_op(logic [1:0] f, logic signed [31:0] v);
		depq_result_t r;
		int pos;
		r.value = '0;
		if (f == FUNC_INSERT) begin
			if (store_model.size() >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				pos = store_model.size();
				while (pos > 0 && store_model[pos-1] > v)
					pos--;
				store_model.insert(pos, v);
				r.st = ST_INSERTED;
			end
		end else if (store_model.size() == 0) begin
			r.st = ST_EMPTY;
		end else begin
			r.st = ST_EXTRACTED;
			if (f == FUNC_MAX)
				r.value = store_model.pop_back();
			else
				r.value = store_model.pop_front();
		end
		return r;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom_range(15) - 8;
			1: begin
				case ($urandom_range(3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_extract();
		case ($urandom_range(9))
			0: return FUNC_UNUSED;
			1, 2, 3, 4: return FUNC_MAX;
			default: return FUNC_MIN;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] f, input logic signed [31:0] v);
		int gap;
		in_valid <= 1'b1;
		func <= f;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_op(f, v));
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		depq_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value=%0d status=%0d",
					$time, result_value, status);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st) begin
					$display("%0t: status mismatch expected=%0d actual=%0d",
						$time, exp_r.st, status);
					errors++;
				end
				if (result_value !== exp_r.value) begin
					$display("%0t: result_value mismatch expected=%0d actual=%0d",
						$time, exp_r.value, result_value);
					errors++;
				end
			end
		end
	end

	task automatic test_empty_extracts();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(FUNC_MAX, 32'sh7fffffff);
		send_item(FUNC_MIN, 32'sh80000000);
		send_item(FUNC_UNUSED, -32'sd1);
		wait_results_done();
	endtask

	task automatic test_extremes();
		send_item(FUNC_INSERT, 32'sh7fffffff);
		send_item(FUNC_INSERT, 32'sh80000000);
		send_item(FUNC_INSERT, 32'sd0);
		send_item(FUNC_INSERT, -32'sd1);
		send_item(FUNC_INSERT, 32'sd1);
		send_item(FUNC_INSERT, 32'sh7fffffff);
		send_item(FUNC_INSERT, 32'sh80000000);
		send_item(FUNC_MAX, 32'sd0);
		send_item(FUNC_MIN, 32'sd0);
		send_item(FUNC_MAX, 32'sd0);
		send_item(FUNC_UNUSED, 32'sd0);
		send_item(FUNC_INSERT, 32'sd5);
		send_item(FUNC_INSERT, 32'sd5);
		send_item(FUNC_INSERT, 32'sd5);
		send_item(FUNC_MIN, 32'sd0);
		send_item(FUNC_MAX, 32'sd0);
		send_item(FUNC_MAX, 32'sd0);
		send_item(FUNC_MIN, 32'sd0);
		send_item(FUNC_MAX, 32'sd0);
		send_item(FUNC_MIN, 32'sd0);
		send_item(FUNC_MAX, 32'sd0);
		wait_results_done();
	endtask

	task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
		int ins_pct;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n_items) begin
			if (store_model.size() < 4)
				ins_pct = 75;
			else if (store_model.size() > 60)
				ins_pct = 30;
			else
				ins_pct = 50;
			if ($urandom_range(99) < ins_pct)
				send_item(FUNC_INSERT, pick_value());
			else
				send_item(pick_extract(), $urandom);
		end
		wait_results_done();
	endtask

	task automatic test_random();
		run_random_phase(140, 0, 0);
		run_random_phase(140, 81, 0);
		run_random_phase(140, 0, 81);
		run_random_phase(140, 16, 16);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_extracts();
		test_extremes();
		test_random();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
